FILE: hdl/spcr_pkg.sv
`timescale 1ns / 1ps
package spcr_pkg;

    localparam int unsigned QueueDepth = 2;

    typedef enum logic [2:0] {
        OP_MOVE  = 3'd0,
        OP_LINE  = 3'd1,
        OP_QUAD  = 3'd2,
        OP_CUBIC = 3'd3,
        OP_ARC   = 3'd4,
        OP_CLOSE = 3'd5,
        OP_BAD   = 3'd6
    } t_seg_op;

    typedef enum logic [3:0] {
        CL_MOVE, CL_LINE, CL_HORIZ, CL_VERT, CL_CUBIC, CL_SMOOTH_CUBIC,
        CL_QUAD, CL_SMOOTH_QUAD, CL_ARC, CL_CLOSE, CL_BAD
    } t_cmd_class;

    localparam logic [7:0] RESET_CMD = 8'h6D;

    typedef struct packed {
        logic [7:0]         kind;
        logic               first_of_verb;
        logic               new_path;
        logic signed [31:0] arg_0;
        logic signed [31:0] arg_1;
        logic signed [31:0] arg_2;
        logic signed [31:0] arg_3;
        logic signed [31:0] arg_4;
        logic signed [31:0] arg_5;
        logic signed [31:0] arg_6;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         segment_op;
        logic signed [31:0] ctrl1_x;
        logic signed [31:0] ctrl1_y;
        logic signed [31:0] ctrl2_x;
        logic signed [31:0] ctrl2_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic               large_arc;
        logic               arc_clockwise;
        logic               last;
    } t_out_item;

    typedef struct packed {
        t_cmd_class         cls;
        logic               rel;
        logic               first;
        logic               new_path;
        logic               after_cubic;
        logic               after_quad;
        logic               arc_big;
        logic               cw;
        logic [31:0]        a0;
        logic [31:0]        a1;
        logic [31:0]        a2;
        logic [31:0]        a3;
        logic [31:0]        a4;
        logic [31:0]        a5;
        logic [31:0]        a6;
    } t_cmd;

endpackage

FILE: hdl/spcr_front.sv
`timescale 1ns / 1ps
module spcr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spcr_pkg::t_in_item i_item,
    input  logic              i_push,
    output logic              o_full,
    output spcr_pkg::t_cmd    o_cmd,
    output logic              o_valid,
    input  logic              i_ready
);
    logic [7:0]        r_prior;
    logic [7:0]        prior;
    spcr_pkg::t_cmd_class cls;
    logic              acc;

    assign o_full  = !i_ready;
    assign o_valid = i_push;
    assign acc     = i_push && i_ready;
    assign prior   = i_item.new_path ? spcr_pkg::RESET_CMD : r_prior;

    always_comb begin
        unique case (i_item.kind)
            "M", "m": cls = spcr_pkg::CL_MOVE;
            "L", "l": cls = spcr_pkg::CL_LINE;
            "H", "h": cls = spcr_pkg::CL_HORIZ;
            "V", "v": cls = spcr_pkg::CL_VERT;
            "C", "c": cls = spcr_pkg::CL_CUBIC;
            "S", "s": cls = spcr_pkg::CL_SMOOTH_CUBIC;
            "Q", "q": cls = spcr_pkg::CL_QUAD;
            "T", "t": cls = spcr_pkg::CL_SMOOTH_QUAD;
            "A", "a": cls = spcr_pkg::CL_ARC;
            "Z", "z": cls = spcr_pkg::CL_CLOSE;
            default:  cls = spcr_pkg::CL_BAD;
        endcase
    end

    always_comb begin
        o_cmd.cls         = cls;
        o_cmd.rel         = (i_item.kind >= "a") && (i_item.kind <= "z");
        o_cmd.first       = i_item.first_of_verb;
        o_cmd.new_path    = i_item.new_path;
        o_cmd.after_cubic = prior == "c" || prior == "C" || prior == "s" || prior == "S";
        o_cmd.after_quad  = prior == "q" || prior == "Q" || prior == "t" || prior == "T";
        o_cmd.arc_big     = i_item.arg_3 != '0;
        o_cmd.cw          = i_item.arg_4 != '0;
        o_cmd.a0          = i_item.arg_0;
        o_cmd.a1          = i_item.arg_1;
        o_cmd.a2          = i_item.arg_2;
        o_cmd.a3          = i_item.arg_3;
        o_cmd.a4          = i_item.arg_4;
        o_cmd.a5          = i_item.arg_5;
        o_cmd.a6          = i_item.arg_6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior <= spcr_pkg::RESET_CMD;
        end else if (acc) begin
            r_prior <= i_item.kind;
        end
    end
endmodule

FILE: hdl/spcr_queue.sv
`timescale 1ns / 1ps
module spcr_queue #(
    parameter int unsigned Depth = spcr_pkg::QueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spcr_pkg::t_cmd i_cmd,
    input  logic           i_valid,
    output logic           o_ready,
    output spcr_pkg::t_cmd o_cmd,
    output logic           o_valid,
    input  logic           i_ready
);
    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
    spcr_pkg::t_cmd  r_mem [Depth];
    logic [Aw-1:0]   r_wp, r_rp;
    logic [Aw:0]     r_cnt;
    logic            wr, rd;

    assign o_ready = r_cnt != Aw'(0) + (Aw+1)'(Depth);
    assign o_valid = r_cnt != '0;
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == Aw'(Depth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == Aw'(Depth - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Aw+1)'(wr) - (Aw+1)'(rd);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Aw+1)'(Depth)) else $error("queue count overflow");
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (Aw+1)'(Depth)) && !rd |=> r_cnt == (Aw+1)'(Depth))
        else $error("queue count changed while full");
    a_empty_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) && !wr |=> r_cnt == '0) else $error("queue count rose with no write");
endmodule

FILE: hdl/spcr_back.sv
`timescale 1ns / 1ps
module spcr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spcr_pkg::t_cmd     i_cmd,
    input  logic               i_valid,
    output logic               o_ready,
    output spcr_pkg::t_out_item o_item,
    output logic               o_empty,
    input  logic               i_pop
);
    logic [31:0] r_px, r_py, r_cx, r_cy, r_sx, r_sy;
    logic [31:0] n_px, n_py, n_cx, n_cy, n_sx, n_sy;
    logic [31:0] px, py, cx, cy, sx, sy, bx, by, rfx, rfy;
    spcr_pkg::t_out_item r_out, n_out;
    logic        r_full, r_pend;
    logic        take, emit_move, out_free;

    assign o_item   = r_out;
    assign o_empty  = !r_full;
    assign out_free = !r_full || i_pop;
    assign o_ready  = out_free && !r_pend;
    assign take     = i_valid && o_ready;
    assign emit_move = r_pend && out_free;

    always_comb begin
        px = i_cmd.new_path ? '0 : r_px;
        py = i_cmd.new_path ? '0 : r_py;
        cx = i_cmd.new_path ? '0 : r_cx;
        cy = i_cmd.new_path ? '0 : r_cy;
        sx = i_cmd.new_path ? '0 : r_sx;
        sy = i_cmd.new_path ? '0 : r_sy;
        bx = i_cmd.rel ? px : '0;
        by = i_cmd.rel ? py : '0;
        rfx = {px[30:0], 1'b0} - cx;
        rfy = {py[30:0], 1'b0} - cy;
        n_px = px; n_py = py; n_cx = cx; n_cy = cy; n_sx = sx; n_sy = sy;
        n_out = '0;
        n_out.last = 1'b1;
        unique case (i_cmd.cls)
            spcr_pkg::CL_MOVE: begin
                n_px = bx + i_cmd.a0; n_py = by + i_cmd.a1;
                if (i_cmd.first) begin
                    n_sx = n_px; n_sy = n_py;
                end
                n_out.segment_op = i_cmd.first ? spcr_pkg::OP_MOVE : spcr_pkg::OP_LINE;
            end
            spcr_pkg::CL_LINE: begin
                n_px = bx + i_cmd.a0; n_py = by + i_cmd.a1;
                n_out.segment_op = spcr_pkg::OP_LINE;
            end
            spcr_pkg::CL_HORIZ: begin
                n_px = bx + i_cmd.a0;
                n_out.segment_op = spcr_pkg::OP_LINE;
            end
            spcr_pkg::CL_VERT: begin
                n_py = by + i_cmd.a0;
                n_out.segment_op = spcr_pkg::OP_LINE;
            end
            spcr_pkg::CL_CUBIC: begin
                n_out.ctrl1_x = bx + i_cmd.a0; n_out.ctrl1_y = by + i_cmd.a1;
                n_cx = bx + i_cmd.a2; n_cy = by + i_cmd.a3;
                n_px = bx + i_cmd.a4; n_py = by + i_cmd.a5;
                n_out.ctrl2_x = n_cx; n_out.ctrl2_y = n_cy;
                n_out.segment_op = spcr_pkg::OP_CUBIC;
            end
            spcr_pkg::CL_SMOOTH_CUBIC: begin
                n_out.ctrl1_x = i_cmd.after_cubic ? rfx : px;
                n_out.ctrl1_y = i_cmd.after_cubic ? rfy : py;
                n_cx = bx + i_cmd.a0; n_cy = by + i_cmd.a1;
                n_px = bx + i_cmd.a2; n_py = by + i_cmd.a3;
                n_out.ctrl2_x = n_cx; n_out.ctrl2_y = n_cy;
                n_out.segment_op = spcr_pkg::OP_CUBIC;
            end
            spcr_pkg::CL_QUAD: begin
                n_cx = bx + i_cmd.a0; n_cy = by + i_cmd.a1;
                n_px = bx + i_cmd.a2; n_py = by + i_cmd.a3;
                n_out.ctrl1_x = n_cx; n_out.ctrl1_y = n_cy;
                n_out.segment_op = spcr_pkg::OP_QUAD;
            end
            spcr_pkg::CL_SMOOTH_QUAD: begin
                n_cx = i_cmd.after_quad ? rfx : px;
                n_cy = i_cmd.after_quad ? rfy : py;
                n_px = bx + i_cmd.a0; n_py = by + i_cmd.a1;
                n_out.ctrl1_x = n_cx; n_out.ctrl1_y = n_cy;
                n_out.segment_op = spcr_pkg::OP_QUAD;
            end
            spcr_pkg::CL_ARC: begin
                n_px = bx + i_cmd.a5; n_py = by + i_cmd.a6;
                n_cx = n_px; n_cy = n_py;
                n_out.ctrl1_x = i_cmd.a0; n_out.ctrl1_y = i_cmd.a1;
                n_out.ctrl2_x = i_cmd.a2;
                n_out.large_arc = i_cmd.arc_big; n_out.arc_clockwise = i_cmd.cw;
                n_out.segment_op = spcr_pkg::OP_ARC;
            end
            spcr_pkg::CL_CLOSE: begin
                n_px = sx; n_py = sy; n_cx = sx; n_cy = sy;
                n_out.segment_op = spcr_pkg::OP_CLOSE;
                n_out.last = 1'b0;
            end
            default: begin
                n_out.segment_op = spcr_pkg::OP_BAD;
            end
        endcase
        if (i_cmd.cls != spcr_pkg::CL_BAD) begin
            n_out.end_x = n_px; n_out.end_y = n_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0; r_py <= '0; r_cx <= '0; r_cy <= '0; r_sx <= '0; r_sy <= '0;
        end else if (take) begin
            r_px <= n_px; r_py <= n_py; r_cx <= n_cx;
            r_cy <= n_cy; r_sx <= n_sx; r_sy <= n_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end else if (emit_move) begin
            r_out <= '{segment_op: spcr_pkg::OP_MOVE, end_x: r_px, end_y: r_py,
                       last: 1'b1, default: '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (take || emit_move) begin
                r_full <= 1'b1;
            end else if (i_pop) begin
                r_full <= 1'b0;
            end
            if (take) begin
                r_pend <= i_cmd.cls == spcr_pkg::CL_CLOSE;
            end else if (emit_move) begin
                r_pend <= 1'b0;
            end
        end
    end

    a_pend_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_full) else $error("pending move without close shown");
    a_close_then_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_move |=> r_full && r_out.last && r_out.segment_op == spcr_pkg::OP_MOVE)
        else $error("move after close missing");
    a_no_take_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !take) else $error("item taken during close");
endmodule

FILE: hdl/svg_path_command_resolver.sv
`timescale 1ns / 1ps
// Resolves SVG path commands, one operand group per item, into absolute segments
// in Q16.16. A front stage classifies the letter and tracks the previous command,
// a two-entry queue decouples it from the back stage, which holds the pen, control
// and subpath-start registers and a one-item output register. One item per cycle is
// sustained unless pop stalls; Z yields two results (close, then move) and takes no new item between them.
module svg_path_command_resolver #(
    parameter int unsigned QueueDepth = spcr_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spcr_pkg::t_in_item  i_item,
    input  logic                push,
    output logic                full,
    output spcr_pkg::t_out_item o_item,
    output logic                empty,
    input  logic                pop
);
    spcr_pkg::t_cmd f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    spcr_front u_front (
        .i_clk, .i_rst_n, .i_item, .i_push(push), .o_full(full),
        .o_cmd(f_cmd), .o_valid(f_valid), .i_ready(f_ready)
    );

    spcr_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk, .i_rst_n, .i_cmd(f_cmd), .i_valid(f_valid), .o_ready(f_ready),
        .o_cmd(q_cmd), .o_valid(q_valid), .i_ready(q_ready)
    );

    spcr_back u_back (
        .i_clk, .i_rst_n, .i_cmd(q_cmd), .i_valid(q_valid), .o_ready(q_ready),
        .o_item, .o_empty(empty), .i_pop(pop)
    );
endmodule

FILE: dv/svg_path_checker.sv
`timescale 1ns / 1ps
module svg_path_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spcr_pkg::t_in_item  i_item,
    input  logic                i_push,
    input  logic                i_full,
    input  spcr_pkg::t_out_item i_seg,
    input  logic                i_empty,
    input  logic                i_pop,
    output int                  o_errors,
    output int                  o_pending
);
    logic [31:0] pen_x, pen_y, ctl_x, ctl_y, start_x, start_y;
    logic [7:0]  prev_kind;
    spcr_pkg::t_out_item expected_segs[$];

    function automatic spcr_pkg::t_out_item make_seg(spcr_pkg::t_seg_op op,
                                           logic [31:0] c1x, logic [31:0] c1y,
                                           logic [31:0] c2x, logic [31:0] c2y,
                                           logic [31:0] ex, logic [31:0] ey,
                                           logic lg, logic cw, logic fin);
        spcr_pkg::t_out_item s;
        s.segment_op = op;
        s.ctrl1_x = c1x;
        s.ctrl1_y = c1y;
        s.ctrl2_x = c2x;
        s.ctrl2_y = c2y;
        s.end_x = ex;
        s.end_y = ey;
        s.large_arc = lg;
        s.arc_clockwise = cw;
        s.last = fin;
        return s;
    endfunction

    task automatic resolve_command(input spcr_pkg::t_in_item it);
        logic        rel, aft_c, aft_q;
        logic [31:0] bx, by, c1x, c1y, c2x, c2y, ex, ey;
        if (it.new_path) begin
            pen_x = 0; pen_y = 0; ctl_x = 0; ctl_y = 0;
            start_x = 0; start_y = 0; prev_kind = spcr_pkg::RESET_CMD;
        end
        rel = it.kind >= "a" && it.kind <= "z";
        bx = rel ? pen_x : 32'd0;
        by = rel ? pen_y : 32'd0;
        aft_c = prev_kind inside {"c", "C", "s", "S"};
        aft_q = prev_kind inside {"q", "Q", "t", "T"};
        case (it.kind)
            "M", "m": begin
                ex = bx + it.arg_0; ey = by + it.arg_1;
                pen_x = ex; pen_y = ey;
                if (it.first_of_verb) begin
                    start_x = ex; start_y = ey;
                    expected_segs.push_back(make_seg(spcr_pkg::OP_MOVE, 0, 0, 0, 0, ex, ey,
                                                     0, 0, 1));
                end else begin
                    expected_segs.push_back(make_seg(spcr_pkg::OP_LINE, 0, 0, 0, 0, ex, ey,
                                                     0, 0, 1));
                end
            end
            "L", "l": begin
                pen_x = bx + it.arg_0; pen_y = by + it.arg_1;
                expected_segs.push_back(make_seg(spcr_pkg::OP_LINE, 0, 0, 0, 0, pen_x, pen_y,
                                                 0, 0, 1));
            end
            "H", "h": begin
                pen_x = bx + it.arg_0;
                expected_segs.push_back(make_seg(spcr_pkg::OP_LINE, 0, 0, 0, 0, pen_x, pen_y,
                                                 0, 0, 1));
            end
            "V", "v": begin
                pen_y = by + it.arg_0;
                expected_segs.push_back(make_seg(spcr_pkg::OP_LINE, 0, 0, 0, 0, pen_x, pen_y,
                                                 0, 0, 1));
            end
            "C", "c": begin
                c1x = bx + it.arg_0; c1y = by + it.arg_1;
                c2x = bx + it.arg_2; c2y = by + it.arg_3;
                ex = bx + it.arg_4; ey = by + it.arg_5;
                ctl_x = c2x; ctl_y = c2y; pen_x = ex; pen_y = ey;
                expected_segs.push_back(make_seg(spcr_pkg::OP_CUBIC, c1x, c1y, c2x, c2y, ex, ey,
                                                 0, 0, 1));
            end
            "S", "s": begin
                c1x = aft_c ? 2 * pen_x - ctl_x : pen_x;
                c1y = aft_c ? 2 * pen_y - ctl_y : pen_y;
                c2x = bx + it.arg_0; c2y = by + it.arg_1;
                ex = bx + it.arg_2; ey = by + it.arg_3;
                ctl_x = c2x; ctl_y = c2y; pen_x = ex; pen_y = ey;
                expected_segs.push_back(make_seg(spcr_pkg::OP_CUBIC, c1x, c1y, c2x, c2y, ex, ey,
                                                 0, 0, 1));
            end
            "Q", "q": begin
                c1x = bx + it.arg_0; c1y = by + it.arg_1;
                ex = bx + it.arg_2; ey = by + it.arg_3;
                ctl_x = c1x; ctl_y = c1y; pen_x = ex; pen_y = ey;
                expected_segs.push_back(make_seg(spcr_pkg::OP_QUAD, c1x, c1y, 0, 0, ex, ey,
                                                 0, 0, 1));
            end
            "T", "t": begin
                c1x = aft_q ? 2 * pen_x - ctl_x : pen_x;
                c1y = aft_q ? 2 * pen_y - ctl_y : pen_y;
                ex = bx + it.arg_0; ey = by + it.arg_1;
                ctl_x = c1x; ctl_y = c1y; pen_x = ex; pen_y = ey;
                expected_segs.push_back(make_seg(spcr_pkg::OP_QUAD, c1x, c1y, 0, 0, ex, ey,
                                                 0, 0, 1));
            end
            "A", "a": begin
                ex = bx + it.arg_5; ey = by + it.arg_6;
                pen_x = ex; pen_y = ey; ctl_x = ex; ctl_y = ey;
                expected_segs.push_back(make_seg(spcr_pkg::OP_ARC, it.arg_0, it.arg_1, it.arg_2,
                                                 0, ex, ey, it.arg_3 != 0, it.arg_4 != 0, 1));
            end
            "Z", "z": begin
                pen_x = start_x; pen_y = start_y; ctl_x = start_x; ctl_y = start_y;
                expected_segs.push_back(make_seg(spcr_pkg::OP_CLOSE, 0, 0, 0, 0, pen_x, pen_y,
                                                 0, 0, 0));
                expected_segs.push_back(make_seg(spcr_pkg::OP_MOVE, 0, 0, 0, 0, pen_x, pen_y,
                                                 0, 0, 1));
            end
            default: expected_segs.push_back(make_seg(spcr_pkg::OP_BAD, 0, 0, 0, 0, 0, 0,
                                                      0, 0, 1));
        endcase
        prev_kind = it.kind;
    endtask

    always @(posedge i_clk) begin
        spcr_pkg::t_out_item want;
        if (!i_rst_n) begin
            pen_x = 0; pen_y = 0; ctl_x = 0; ctl_y = 0;
            start_x = 0; start_y = 0; prev_kind = spcr_pkg::RESET_CMD;
            expected_segs.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_push && !i_full) resolve_command(i_item);
            if (i_pop && !i_empty) begin
                if (expected_segs.size() == 0) begin
                    $display("%0t: unexpected segment %h", $time, i_seg);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_segs.pop_front();
                    if (i_seg !== want) begin
                        $display("%0t: segment mismatch expected %h actual %h",
                                 $time, want, i_seg);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_segs.size();
        end
    end
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
    logic       clk, rst_n, push, full, empty, pop;
    spcr_pkg::t_in_item   item;
    spcr_pkg::t_out_item  seg;
    int         errors, pending, cycles;
    bit         stim_done;

    localparam byte unsigned Letters[20] = '{"M", "m", "L", "l", "H", "h", "V", "v", "C", "c",
                                             "S", "s", "Q", "q", "T", "t", "A", "a", "Z", "z"};

    svg_path_command_resolver dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_item(item), .push(push), .full(full),
        .o_item(seg), .empty(empty), .pop(pop)
    );

    svg_path_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_item(item), .i_push(push), .i_full(full),
        .i_seg(seg), .i_empty(empty), .i_pop(pop), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] rand_arg();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic [7:0] k, input logic fv, input logic np,
                        input logic [31:0] a0, input logic [31:0] a1, input logic [31:0] a2,
                        input logic [31:0] a3, input logic [31:0] a4, input logic [31:0] a5,
                        input logic [31:0] a6);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= '{k, fv, np, a0, a1, a2, a3, a4, a5, a6};
        push <= 1'b1;
        do @(posedge clk); while (full);
    endtask

    task automatic send_rand(input logic [7:0] k, input logic fv, input logic np);
        send(k, fv, np, rand_arg(), rand_arg(), rand_arg(), rand_arg(),
             rand_arg(), rand_arg(), rand_arg());
    endtask

    initial begin
        push = 0;
        item = '0;
        rst_n = 0;
        stim_done = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send("S", 1, 0, 32'h7fff_ffff, 32'h8000_0000, 1, 2, 0, 0, 0);
        send("C", 1, 0, 32'h8000_0000, 32'h7fff_ffff, 5, 6, 7, 8, 0);
        send("s", 1, 0, 32'hffff_ffff, 3, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
        send("T", 1, 0, 9, 9, 0, 0, 0, 0, 0);
        send("q", 1, 0, 32'h7fff_ffff, 4, 32'h8000_0000, 1, 0, 0, 0);
        send("t", 1, 0, 10, 20, 0, 0, 0, 0, 0);
        send("A", 1, 0, 1, 2, 3, 0, 0, 4, 5);
        send("a", 0, 0, 1, 2, 3, 32'h8000_0000, 1, 32'h7fff_ffff, 32'hffff_ffff);
        send("m", 1, 0, 100, 200, 0, 0, 0, 0, 0);
        send("m", 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 0);
        send("H", 1, 0, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0);
        send("v", 1, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        send("h", 1, 0, 7, 0, 0, 0, 0, 0, 0);
        send("V", 1, 0, 8, 0, 0, 0, 0, 0, 0);
        send("L", 1, 0, 1, 1, 0, 0, 0, 0, 0);
        send("l", 1, 0, 2, 2, 0, 0, 0, 0, 0);
        send("z", 1, 0, 0, 0, 0, 0, 0, 0, 0);
        send("X", 1, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send(8'hff, 1, 1, 0, 0, 0, 0, 0, 0, 0);
        send("Z", 1, 1, 0, 0, 0, 0, 0, 0, 0);
        send("M", 1, 0, 5, 5, 0, 0, 0, 0, 0);
        for (int n = 0; n < 1750; ) begin
            int len;
            byte unsigned k;
            if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(0, 9) < 3 ? Letters[$urandom_range(0, 19)] : 8'($urandom);
                send_rand(k, 1'($urandom), 1'($urandom));
                n++;
            end else begin
                send_rand($urandom_range(0, 1) ? "M" : "m", 1, $urandom_range(0, 7) == 0);
                n++;
                len = $urandom_range(1, 8);
                for (int j = 0; j < len; j++) begin
                    int grp;
                    k = Letters[$urandom_range(0, 17)];
                    grp = $urandom_range(1, 3);
                    for (int g = 0; g < grp; g++) begin
                        send_rand(k, g == 0, 0);
                        n++;
                    end
                end
                if ($urandom_range(0, 1)) begin
                    send_rand($urandom_range(0, 1) ? "Z" : "z", 1, 0);
                    n++;
                end
            end
        end
        push <= 1'b0;
        stim_done = 1;
    end

    initial begin
        pop = 0;
        @(posedge rst_n);
        forever begin
            int gap;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000) begin
                $display("simulation failed");
                $finish;
            end
            if (stim_done && pending == 0) begin
                repeat (20) @(posedge clk);
                if (errors == 0 && empty && pending == 0) begin
                    $display("simulation ok");
                end else begin
                    if (!empty || pending != 0) $display("%0t: extra segment pending", $time);
                    $display("simulation failed");
                end
                $finish;
            end
        end
    end
endmodule
